// ===== rtl/core/ctlex_pkg.sv =====
// Shared types, token kinds and byte classification for the calculator token lexer.
package ctlex_pkg;

  localparam logic [3:0] KIND_NUM    = 4'd0;
  localparam logic [3:0] KIND_IDENT  = 4'd1;
  localparam logic [3:0] KIND_LET    = 4'd2;
  localparam logic [3:0] KIND_PRINT  = 4'd3;
  localparam logic [3:0] KIND_PLUS   = 4'd4;
  localparam logic [3:0] KIND_MINUS  = 4'd5;
  localparam logic [3:0] KIND_STAR   = 4'd6;
  localparam logic [3:0] KIND_SLASH  = 4'd7;
  localparam logic [3:0] KIND_LPAREN = 4'd8;
  localparam logic [3:0] KIND_RPAREN = 4'd9;
  localparam logic [3:0] KIND_ASSIGN = 4'd10;
  localparam logic [3:0] KIND_SEMI   = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam int OUT_DATA_W = 176;

  typedef enum logic [1:0] {
    CLS_ABSORB    = 2'd0,
    CLS_DIRECT    = 2'd1,
    CLS_FLUSH_NUM = 2'd2,
    CLS_FLUSH_ID  = 2'd3
  } cls_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic emit_word;
    logic fresh;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic slot_free;
    logic last_word;
    logic own_emits;
  } sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "(") || (c == ")") || (c == "=") || (c == ";");
  endfunction

  function automatic logic [3:0] op_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "=":     k = KIND_ASSIGN;
      ";":     k = KIND_SEMI;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // true when a byte taken from idle yields a token of its own
  function automatic logic byte_emits(input logic [7:0] c);
    return !(is_blank(c) || (c == CH_NL) || (c == CH_HASH) || is_digit(c) || is_alpha(c));
  endfunction

  function automatic logic [7:0] let_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = "l";
      2'd1:    r = "e";
      2'd2:    r = "t";
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] print_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "p";
      3'd1:    r = "r";
      3'd2:    r = "i";
      3'd3:    r = "n";
      3'd4:    r = "t";
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ctlex_ctrl.sv =====
// Sequencer for the token lexer: byte intake, identifier word readout, deferred byte.
module ctlex_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ctlex_pkg::sts_t   sts,
  output ctlex_pkg::cmd_t   cmd
);
  import ctlex_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'b0001,
    ST_RD     = 4'b0010,
    ST_WORD   = 4'b0100,
    ST_OWN    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_ACCEPT: begin
        in_tready  = sts.slot_free;
        cmd.accept = in_tvalid && sts.slot_free;
        if (cmd.accept) begin
          case (sts.cls)
            CLS_FLUSH_NUM: state_nxt = ST_OWN;
            CLS_FLUSH_ID:  state_nxt = ST_RD;
            default:       state_nxt = ST_ACCEPT;
          endcase
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WORD;
      end
      ST_WORD: begin
        if (sts.slot_free) begin
          cmd.emit_word = 1'b1;
          state_nxt     = sts.last_word ? ST_OWN : ST_RD;
        end
      end
      ST_OWN: begin
        if (!sts.own_emits || sts.slot_free) begin
          cmd.fresh = 1'b1;
          state_nxt = ST_ACCEPT;
        end
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.rd, cmd.emit_word, cmd.fresh}))
    else $error("more than one datapath command");
  a_word_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_word |-> sts.slot_free)
    else $error("word emitted into busy output slot");
  a_id_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.cls == CLS_FLUSH_ID) |=> cmd.rd)
    else $error("identifier flush did not start a read");
`endif

endmodule

// ===== rtl/core/ctlex_dp.sv =====
// Lexer datapath: scan mode, number accumulator, identifier store, line counts, output beat.
module ctlex_dp #(
  parameter int IDENT_MAX = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [7:0]                        in_tdata,
  input  ctlex_pkg::cmd_t                   cmd,
  output ctlex_pkg::sts_t                   sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctlex_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);
  import ctlex_pkg::*;

  localparam int CW   = $clog2(IDENT_MAX + 1);
  localparam int ROWS = (IDENT_MAX + 7) / 8;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_NUMBER  = 5'b00010,
    M_IDENT   = 5'b00100,
    M_COMMENT = 5'b01000,
    M_DRAIN   = 5'b10000
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           let_ok_r, let_ok_nxt;
  logic           print_ok_r, print_ok_nxt;
  logic [31:0]    line_r, line_nxt;
  logic [31:0]    tok_line_r, tok_line_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic [RW-1:0]  widx_r, widx_nxt;
  logic [63:0]    rd_r;
  logic [63:0]    mem [ROWS];

  logic           out_valid_r, out_valid_nxt;
  logic [3:0]     kind_r, kind_nxt;
  logic [63:0]    value_r, value_nxt;
  logic [63:0]    word_r, word_nxt;
  logic [5:0]     tlen_r, tlen_nxt;
  logic [31:0]    oline_r, oline_nxt;
  logic           last_r, last_nxt;

  logic           wr_en;
  logic [RW-1:0]  wr_row;
  logic [2:0]     wr_lane;
  logic [7:0]     wr_byte;

  cls_t           cls;
  logic [7:0]     fb;
  logic           do_fresh, do_absorb, slot_free, last_word;
  logic [CW-1:0]  base, rem, cnt_m1;
  logic [63:0]    word_mask;
  logic [3:0]     id_kind;

  assign slot_free = !out_valid_r || out_tready;
  assign cnt_m1    = count_r - CW'(1);
  assign last_word = (widx_r == RW'(cnt_m1 >> 3));
  assign base      = CW'({widx_r, 3'b000});
  assign rem       = count_r - base;
  assign id_kind   = ((count_r == CW'(3)) && let_ok_r)   ? KIND_LET   :
                     ((count_r == CW'(5)) && print_ok_r) ? KIND_PRINT : KIND_IDENT;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word_mask[b*8 +: 8] = (rem > CW'(b)) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    case (mode_r)
      M_IDLE:    cls = CLS_DIRECT;
      M_NUMBER:  cls = is_digit(in_tdata) ? CLS_ABSORB : CLS_FLUSH_NUM;
      M_IDENT:   cls = (is_alpha(in_tdata) || is_digit(in_tdata)) ? CLS_ABSORB : CLS_FLUSH_ID;
      M_COMMENT: cls = ((in_tdata == CH_NUL) || (in_tdata == CH_NL)) ? CLS_DIRECT : CLS_ABSORB;
      M_DRAIN:   cls = (in_tdata == CH_NUL) ? CLS_DIRECT : CLS_ABSORB;
      default:   cls = CLS_DIRECT;
    endcase
  end

  assign sts.cls       = cls;
  assign sts.slot_free = slot_free;
  assign sts.last_word = last_word;
  assign sts.own_emits = byte_emits(byte_r);

  assign fb        = cmd.fresh ? byte_r : in_tdata;
  assign do_fresh  = (cmd.accept && (cls == CLS_DIRECT)) || cmd.fresh;
  assign do_absorb = cmd.accept && (cls == CLS_ABSORB);

  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    count_nxt     = count_r;
    let_ok_nxt    = let_ok_r;
    print_ok_nxt  = print_ok_r;
    line_nxt      = line_r;
    tok_line_nxt  = tok_line_r;
    byte_nxt      = byte_r;
    widx_nxt      = widx_r;
    wr_en         = 1'b0;
    wr_row        = RW'(count_r >> 3);
    wr_lane       = count_r[2:0];
    wr_byte       = fb;
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    word_nxt      = word_r;
    tlen_nxt      = tlen_r;
    oline_nxt     = oline_r;
    last_nxt      = last_r;

    if (do_absorb) begin
      if (mode_r == M_NUMBER) begin
        acc_nxt = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + 64'(in_tdata - CH_ZERO);
      end else if ((mode_r == M_IDENT) && (count_r < CW'(IDENT_MAX))) begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        if ((count_r < CW'(3)) && (in_tdata != let_char(count_r[1:0]))) begin
          let_ok_nxt = 1'b0;
        end
        if ((count_r < CW'(5)) && (in_tdata != print_char(count_r[2:0]))) begin
          print_ok_nxt = 1'b0;
        end
      end
    end

    if (cmd.accept && (cls == CLS_FLUSH_NUM)) begin
      byte_nxt      = in_tdata;
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_NUM;
      value_nxt     = acc_r;
      word_nxt      = '0;
      tlen_nxt      = '0;
      oline_nxt     = tok_line_r;
      last_nxt      = !byte_emits(in_tdata);
    end

    if (cmd.accept && (cls == CLS_FLUSH_ID)) begin
      byte_nxt = in_tdata;
      widx_nxt = '0;
    end

    if (cmd.emit_word) begin
      widx_nxt      = widx_r + RW'(1);
      out_valid_nxt = 1'b1;
      kind_nxt      = id_kind;
      value_nxt     = '0;
      word_nxt      = rd_r & word_mask;
      tlen_nxt      = 6'(count_r);
      oline_nxt     = tok_line_r;
      last_nxt      = last_word && !byte_emits(byte_r);
    end

    if (do_fresh) begin
      mode_nxt = M_IDLE;
      if (fb == CH_NUL) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_END;
        value_nxt     = '0;
        word_nxt      = '0;
        tlen_nxt      = '0;
        oline_nxt     = line_r;
        last_nxt      = 1'b1;
        line_nxt      = 32'd1;
        tok_line_nxt  = 32'd1;
      end else if (fb == CH_NL) begin
        if (line_r != '1) begin
          line_nxt = line_r + 32'd1;
        end
      end else if (is_blank(fb)) begin
        mode_nxt = M_IDLE;
      end else if (fb == CH_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (is_op(fb)) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = op_kind(fb);
        value_nxt     = '0;
        word_nxt      = '0;
        tlen_nxt      = '0;
        oline_nxt     = line_r;
        last_nxt      = 1'b1;
      end else if (is_digit(fb)) begin
        mode_nxt     = M_NUMBER;
        acc_nxt      = 64'(fb - CH_ZERO);
        tok_line_nxt = line_r;
      end else if (is_alpha(fb)) begin
        mode_nxt     = M_IDENT;
        wr_en        = 1'b1;
        wr_row       = '0;
        wr_lane      = 3'd0;
        count_nxt    = CW'(1);
        let_ok_nxt   = (fb == let_char(2'd0));
        print_ok_nxt = (fb == print_char(3'd0));
        tok_line_nxt = line_r;
      end else begin
        mode_nxt      = M_DRAIN;
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_ERROR;
        value_nxt     = 64'(fb);
        word_nxt      = '0;
        tlen_nxt      = '0;
        oline_nxt     = line_r;
        last_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][{wr_lane, 3'b000} +: 8] <= wr_byte;
    end
    if (cmd.rd) begin
      rd_r <= mem[widx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      acc_r       <= '0;
      count_r     <= '0;
      line_r      <= 32'd1;
      tok_line_r  <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      line_r      <= line_nxt;
      tok_line_r  <= tok_line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    let_ok_r   <= let_ok_nxt;
    print_ok_r <= print_ok_nxt;
    byte_r     <= byte_nxt;
    widx_r     <= widx_nxt;
    kind_r     <= kind_nxt;
    value_r    <= value_nxt;
    word_r     <= word_nxt;
    tlen_r     <= tlen_nxt;
    oline_r    <= oline_nxt;
    last_r     <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'b0, oline_r, tlen_r, word_r, value_r, kind_r};

`ifndef SYNTHESIS
  a_ident_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_IDENT) |-> (count_r != '0))
    else $error("identifier mode with empty store");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 32'd0)
    else $error("line count reached zero");
  a_word_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_word |=> out_valid_r &&
      ((kind_r == KIND_IDENT) || (kind_r == KIND_LET) || (kind_r == KIND_PRINT)))
    else $error("identifier word beat with wrong kind");
`endif

endmodule

// ===== rtl/core/calculator_token_lexer_unit.sv =====
// Top level of the calculator token lexer: sequencer plus datapath.
//
// channel   dir  tdata                                             side band
// in_       in   [7:0] ch                                          -
// out_      out  [3:0] kind, [67:4] value, [131:68] text_word,     tlast = last
//                [137:132] text_len, [169:138] line, rest zero
//
// A byte that continues a token, is blank, or opens or continues a comment keeps the sequencer in
// its accept state. A byte that ends a number is then replayed from the deferred-byte register; one
// that ends an identifier is replayed after each 8-character word of the store is read and emitted.
// Results leave through a single output register; a held output stalls the input side.
// Synchronous active-low reset; the identifier store needs no clearing pass.
module calculator_token_lexer_unit #(
  parameter int IDENT_MAX = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] ch
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctlex_pkg::OUT_DATA_W-1:0]  out_tdata,  // kind, value, text_word, text_len, line
  output logic                              out_tlast
);
  import ctlex_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ctlex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctlex_dp #(
    .IDENT_MAX (IDENT_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
